// ===== rtl/mhpq_pkg.sv =====
// Shared types, constants and the key compare for the max-heap priority queue.
`timescale 1ns / 1ps

package mhpq_pkg;

    localparam int HEAP_DEPTH = 64;
    localparam int ADDR_W     = $clog2(HEAP_DEPTH);
    localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
    localparam int IDX_W      = CNT_W + 1;
    localparam int KEY_W      = 32;
    localparam int REGION_W   = 16;
    localparam int VALUE_W    = 32;
    localparam int ENTRY_W    = KEY_W + REGION_W + VALUE_W;
    localparam int COUNT_OUT_W = 7;

    typedef struct packed {
        logic signed [KEY_W-1:0]   key;
        logic        [REGION_W-1:0] region;
        logic signed [VALUE_W-1:0] value;
    } entry_t;

    typedef enum logic
    {
        OP_INSERT  = 1'b0,
        OP_EXTRACT = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        ST_INSERTED  = 2'd0,
        ST_EXTRACTED = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [3:0]
    {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_DN_LAST,
        S_DN_L_RD,
        S_DN_L,
        S_DN_R,
        S_DN_DEC,
        S_FINISH
    } fsm_t;

    // Signed strict greater-than on keys
    function automatic logic key_gt(input logic signed [KEY_W-1:0] a,
                                    input logic signed [KEY_W-1:0] b);
        key_gt = a > b;
    endfunction

endpackage

// ===== rtl/mhpq_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module mhpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/max_heap_priority_queue.sv =====
// Top level of the binary max-heap priority queue: control sequencer and datapath.
`timescale 1ns / 1ps
//
//  Channel | Direction | Handshake            | Word
//  --------+-----------+----------------------+----------------------------------
//  in      | sink      | in_valid / in_stall  | kind, key, region_id, rate_value
//  out     | source    | out_valid / out_stall| status, top_key, top_region,
//          |           |                      | top_value, entry_count
//
//  Flow: one word at a time, as in_stall is high whenever the sequencer is
//  not idle. An insert climbs through S_UP_RD and S_UP_CMP per level; an
//  extract fetches the last entry, then descends through S_DN_L_RD, S_DN_L,
//  S_DN_R (when a right child exists) and S_DN_DEC per level. The single read
//  port of the entry RAM (one child or parent read per access) sets these steps.
//  Reset: rst_n clears the count, the sequencer and out_valid; the RAM holds no
//  reset value and is never read beyond the count.
//  Stalls: a finished result sits in the output register; the next word is
//  taken while it waits, and only the hand-over of the following result in the
//  finish step waits on out_stall.

module max_heap_priority_queue
    import mhpq_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       kind,
    input  logic signed [KEY_W-1:0]    key,
    input  logic [REGION_W-1:0]        region_id,
    input  logic signed [VALUE_W-1:0]  rate_value,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [1:0]                 status,
    output logic signed [KEY_W-1:0]    top_key,
    output logic [REGION_W-1:0]        top_region,
    output logic signed [VALUE_W-1:0]  top_value,
    output logic [COUNT_OUT_W-1:0]     entry_count
);

    fsm_t               state_reg, state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [ADDR_W-1:0]  pos_reg;
    entry_t             mov_reg;     // entry being sifted
    entry_t             lch_reg;
    entry_t             rch_reg;
    logic               r_ok_reg;
    entry_t             root_reg;    // copy of heap entry 0
    entry_t             res_reg;
    status_t            res_status_reg;

    logic               out_valid_reg;
    status_t            out_status_reg;
    entry_t             out_entry_reg;
    logic [CNT_W-1:0]   out_count_reg;

    // RAM ports
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    entry_t             mem_wdata;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_raddr;
    logic [ENTRY_W-1:0] mem_rdata;
    entry_t             rd_entry;

    logic               accept;
    logic               is_full;
    logic [ADDR_W-1:0]  pos_m1;
    logic [ADDR_W-1:0]  par_idx;
    logic [IDX_W-1:0]   l_idx;
    logic [IDX_W-1:0]   r_idx;
    logic [IDX_W-1:0]   cnt_ext;
    logic               up_gt;
    logic               l_gt;
    logic               r_gt;
    logic signed [KEY_W-1:0] best_key;
    logic               dn_move;
    entry_t             dn_child;
    logic [ADDR_W-1:0]  dn_child_idx;
    logic               out_free;

    assign rd_entry = entry_t'(mem_rdata);
    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign is_full  = (count_reg == CNT_W'(HEAP_DEPTH));
    assign out_free = !out_valid_reg || !out_stall;

    // Index arithmetic: parent (pos-1)/2, children 2pos+1 and 2pos+2
    assign pos_m1  = pos_reg - ADDR_W'(1);
    assign par_idx = pos_m1 >> 1;
    assign l_idx   = IDX_W'({pos_reg, 1'b1});
    assign r_idx   = l_idx + IDX_W'(1);
    assign cnt_ext = IDX_W'(count_reg);

    assign up_gt = key_gt(mov_reg.key, rd_entry.key);

    // Sift-down choice: left wins ties with right; move only on strict greater
    always_comb
    begin
        l_gt     = key_gt(lch_reg.key, mov_reg.key);
        best_key = l_gt ? lch_reg.key : mov_reg.key;
        r_gt     = r_ok_reg && key_gt(rch_reg.key, best_key);
        dn_move  = l_gt || r_gt;
        if (r_gt)
        begin
            dn_child     = rch_reg;
            dn_child_idx = ADDR_W'(l_idx) + ADDR_W'(1);
        end
        else
        begin
            dn_child     = lch_reg;
            dn_child_idx = ADDR_W'(l_idx);
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (op_t'(kind) == OP_INSERT)
                    begin
                        state_next = is_full ? S_FINISH : S_UP_RD;
                    end
                    else if (count_reg <= CNT_W'(1))
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_DN_LAST;
                    end
                end
            end
            S_UP_RD:   state_next = (pos_reg == '0) ? S_FINISH : S_UP_CMP;
            S_UP_CMP:  state_next = up_gt ? S_UP_RD : S_FINISH;
            S_DN_LAST: state_next = S_DN_L_RD;
            S_DN_L_RD: state_next = (l_idx >= cnt_ext) ? S_FINISH : S_DN_L;
            S_DN_L:    state_next = (r_idx < cnt_ext) ? S_DN_R : S_DN_DEC;
            S_DN_R:    state_next = S_DN_DEC;
            S_DN_DEC:  state_next = dn_move ? S_DN_L_RD : S_FINISH;
            S_FINISH:  state_next = out_free ? S_IDLE : S_FINISH;
            default:   state_next = S_IDLE;
        endcase
    end

    // RAM control
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = pos_reg;
        mem_wdata = mov_reg;
        mem_re    = 1'b0;
        mem_raddr = pos_reg;
        case (state_reg)
            S_IDLE:
            begin
                // fetch the last entry for an extract
                if (accept && op_t'(kind) == OP_EXTRACT && count_reg > CNT_W'(1))
                begin
                    mem_re    = 1'b1;
                    mem_raddr = ADDR_W'(count_reg - CNT_W'(1));
                end
            end
            S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    mem_we = 1'b1;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = par_idx;
                end
            end
            S_UP_CMP:
            begin
                // drop the parent into the hole, or settle the new entry
                mem_we = 1'b1;
                if (up_gt)
                begin
                    mem_wdata = rd_entry;
                end
            end
            S_DN_L_RD:
            begin
                if (l_idx >= cnt_ext)
                begin
                    mem_we = 1'b1;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = ADDR_W'(l_idx);
                end
            end
            S_DN_L:
            begin
                if (r_idx < cnt_ext)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = ADDR_W'(r_idx);
                end
            end
            S_DN_DEC:
            begin
                mem_we = 1'b1;
                if (dn_move)
                begin
                    mem_wdata = dn_child;
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_IDLE && accept)
            begin
                if (op_t'(kind) == OP_INSERT && !is_full)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                else if (op_t'(kind) == OP_EXTRACT && count_reg != '0)
                begin
                    count_reg <= count_reg - CNT_W'(1);
                end
            end
            if (state_reg == S_FINISH && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (mem_we && mem_waddr == '0)
        begin
            root_reg <= mem_wdata;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    mov_reg.key    <= key;
                    mov_reg.region <= region_id;
                    mov_reg.value  <= rate_value;
                    pos_reg        <= ADDR_W'(count_reg);
                    if (op_t'(kind) == OP_INSERT)
                    begin
                        res_status_reg <= is_full ? ST_FULL : ST_INSERTED;
                        res_reg        <= root_reg;
                    end
                    else if (count_reg == '0)
                    begin
                        res_status_reg <= ST_EMPTY;
                        res_reg        <= '0;
                    end
                    else
                    begin
                        res_status_reg <= ST_EXTRACTED;
                        res_reg        <= root_reg;
                    end
                end
            end
            S_UP_CMP:
            begin
                if (up_gt)
                begin
                    pos_reg <= par_idx;
                end
            end
            S_DN_LAST:
            begin
                mov_reg <= rd_entry;
                pos_reg <= '0;
            end
            S_DN_L:
            begin
                lch_reg  <= rd_entry;
                r_ok_reg <= (r_idx < cnt_ext);
            end
            S_DN_R:
            begin
                rch_reg <= rd_entry;
            end
            S_DN_DEC:
            begin
                if (dn_move)
                begin
                    pos_reg <= dn_child_idx;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_status_reg <= res_status_reg;
                    out_count_reg  <= count_reg;
                    // an insert reports the root as it stands after the sift
                    out_entry_reg  <= (res_status_reg == ST_INSERTED) ? root_reg : res_reg;
                end
            end
            default:
            begin
                pos_reg <= pos_reg;
            end
        endcase
    end

    mhpq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (HEAP_DEPTH)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (ENTRY_W'(mem_wdata)),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign top_key     = out_entry_reg.key;
    assign top_region  = out_entry_reg.region;
    assign top_value   = out_entry_reg.value;
    assign entry_count = COUNT_OUT_W'(out_count_reg);

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(HEAP_DEPTH))
        else $error("entry count beyond heap depth");

    a_write_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (CNT_W'(mem_waddr) < count_reg))
        else $error("write outside the live heap");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == ST_EMPTY) |->
        (out_count_reg == '0 && out_entry_reg == '0))
        else $error("empty status with non-zero word");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op_t'(kind) == OP_INSERT && !is_full) |=>
        (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not advance the count");

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the max-heap priority queue.
`timescale 1ns / 1ps

module tb_top;
    import mhpq_pkg::*;

    typedef struct packed {
        logic                      kind;
        logic signed [KEY_W-1:0]   key;
        logic [REGION_W-1:0]       region;
        logic signed [VALUE_W-1:0] value;
    } op_word_t;

    typedef struct packed {
        logic [1:0]                status;
        logic signed [KEY_W-1:0]   key;
        logic [REGION_W-1:0]       region;
        logic signed [VALUE_W-1:0] value;
        logic [COUNT_OUT_W-1:0]    count;
    } heap_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic kind = 1'b0;
    logic signed [KEY_W-1:0] key = '0;
    logic [REGION_W-1:0] region_id = '0;
    logic signed [VALUE_W-1:0] rate_value = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [1:0] status;
    logic signed [KEY_W-1:0] top_key;
    logic [REGION_W-1:0] top_region;
    logic signed [VALUE_W-1:0] top_value;
    logic [COUNT_OUT_W-1:0] entry_count;

    max_heap_priority_queue DUT (.*);

    always #4 clk = ~clk;

    // Model of the heap contents, kept in step with accepted words
    entry_t heap_model [HEAP_DEPTH];
    int unsigned heap_fill = 0;

    op_word_t     pending_words[$];
    heap_result_t expected_results[$];
    int unsigned  send_idle_pct = 19;
    int unsigned  recv_idle_pct = 63;
    bit           hold_sender = 1'b0;
    int unsigned  error_count = 0;
    longint unsigned cycle_count = 0;

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        $display("MISMATCH %s: got %0d expected %0d at cycle %0d",
                 what, got, want, cycle_count);
        error_count++;
    endtask

    function automatic void queue_word(input op_word_t w);
        pending_words = {pending_words, w};
    endfunction

    function automatic void queue_result(input heap_result_t r);
        expected_results = {expected_results, r};
    endfunction

    function automatic void swap_slots(input int unsigned a, input int unsigned b);
        entry_t t;
        t = heap_model[a];
        heap_model[a] = heap_model[b];
        heap_model[b] = t;
    endfunction

    // Apply one accepted word to the heap model and queue the expected word
    function automatic void predict_heap_op(input op_word_t w);
        heap_result_t r;
        int unsigned pos;
        int unsigned up;
        int unsigned lc;
        int unsigned rc;
        int unsigned best;
        entry_t removed;
        r = '0;
        if (w.kind == OP_INSERT)
        begin
            if (heap_fill >= HEAP_DEPTH)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                heap_model[heap_fill] = '{w.key, w.region, w.value};
                pos = heap_fill;
                heap_fill++;
                while (pos > 0)
                begin
                    up = (pos - 1) / 2;
                    if (!(heap_model[pos].key > heap_model[up].key))
                        break;
                    swap_slots(pos, up);
                    pos = up;
                end
                r.status = ST_INSERTED;
            end
            r.key = heap_model[0].key;
            r.region = heap_model[0].region;
            r.value = heap_model[0].value;
        end
        else if (heap_fill == 0)
        begin
            r.status = ST_EMPTY;
        end
        else
        begin
            removed = heap_model[0];
            heap_fill--;
            heap_model[0] = heap_model[heap_fill];
            pos = 0;
            forever
            begin
                lc = 2 * pos + 1;
                rc = 2 * pos + 2;
                best = pos;
                if (lc < heap_fill && heap_model[lc].key > heap_model[best].key)
                    best = lc;
                if (rc < heap_fill && heap_model[rc].key > heap_model[best].key)
                    best = rc;
                if (best == pos)
                    break;
                swap_slots(pos, best);
                pos = best;
            end
            r.status = ST_EXTRACTED;
            r.key = removed.key;
            r.region = removed.region;
            r.value = removed.value;
        end
        r.count = heap_fill[COUNT_OUT_W-1:0];
        queue_result(r);
    endfunction

    function automatic op_word_t make_insert(input logic signed [31:0] k,
                                             input logic [15:0] rg,
                                             input logic signed [31:0] v);
        return '{OP_INSERT, k, rg, v};
    endfunction

    function automatic op_word_t make_extract();
        return '{OP_EXTRACT, 32'($urandom), 16'($urandom), 32'($urandom)};
    endfunction

    // Keys from a narrow band often, so that equal keys and ties turn up
    function automatic logic signed [31:0] pick_key();
        case ($urandom_range(3))
            0: return 32'($urandom_range(7));
            1: return -(32'($urandom_range(7)));
            2: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
            default: return 32'($urandom);
        endcase
    endfunction

    // Driver: advance to the next word on acceptance, idle at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
                predict_heap_op('{kind, key, region_id, rate_value});
            if (pending_words.size() > 0 && !hold_sender
                && $urandom_range(99) >= send_idle_pct)
            begin
                op_word_t w;
                w = pending_words.pop_front();
                in_valid <= 1'b1;
                kind <= w.kind;
                key <= w.key;
                region_id <= w.region;
                rate_value <= w.value;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each accepted result word with the oldest expectation
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected result, status", status, -1);
                end
                else
                begin
                    heap_result_t e;
                    e = expected_results.pop_front();
                    if (status !== e.status)
                        report_mismatch("status", status, e.status);
                    if (top_key !== e.key)
                        report_mismatch("top_key", top_key, e.key);
                    if (top_region !== e.region)
                        report_mismatch("top_region", top_region, e.region);
                    if (top_value !== e.value)
                        report_mismatch("top_value", top_value, e.value);
                    if (entry_count !== e.count)
                        report_mismatch("entry_count", entry_count, e.count);
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Drain: wait for the sender to empty and every result to arrive
    task automatic drain_all();
        while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        int unsigned n;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty extract, extremes, ties, drain to empty, fill to full and drop
        queue_word(make_extract());
        queue_word(make_insert(32'sh80000000, 16'h0000, 32'sh80000000));
        queue_word(make_insert(32'sh7fffffff, 16'hffff, 32'sh7fffffff));
        queue_word(make_insert(32'sh7fffffff, 16'h5555, 32'sh0));
        queue_word(make_insert(0, 16'haaaa, -1));
        queue_word(make_insert(0, 16'h1234, 1));
        queue_word(make_insert(-1, 16'h0001, 32'sh12345678));
        repeat (6) queue_word(make_extract());
        queue_word(make_extract());
        for (int i = 0; i < HEAP_DEPTH + 2; i++)
            queue_word(make_insert(pick_key(), 16'($urandom), 32'($urandom)));
        queue_word(make_extract());
        queue_word(make_insert(pick_key(), 16'($urandom), 32'($urandom)));
        queue_word(make_insert(pick_key(), 16'($urandom), 32'($urandom)));
        drain_all();

        // Hold the sender while extracts queue up on the idle block, then release it
        hold_sender = 1'b1;
        for (int i = 0; i < 5; i++)
            queue_word(make_extract());
        repeat (40) @(posedge clk);
        hold_sender = 1'b0;

        // Random runs: bursts of mixed inserts and extracts with a random insert bias
        for (int phase = 0; phase < 3; phase++)
        begin
            if (phase == 1)
            begin
                send_idle_pct = 63;
                recv_idle_pct = 19;
            end
            else if (phase == 2)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            n = 0;
            while (n < 400)
            begin
                int unsigned burst;
                int unsigned bias;
                burst = $urandom_range(1, 80);
                bias = $urandom_range(100);
                for (int i = 0; i < burst; i++)
                begin
                    if ($urandom_range(99) < bias)
                        queue_word(make_insert(pick_key(), 16'($urandom),
                                               32'($urandom)));
                    else
                        queue_word(make_extract());
                end
                n += burst;
            end
            drain_all();
        end

        repeat (60) @(posedge clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Generous limit on the whole run
    always @(posedge clk)
    begin
        if (cycle_count > 400000)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule

// ===== files.f =====
rtl/mhpq_pkg.sv
rtl/mhpq_ram.sv
rtl/max_heap_priority_queue.sv
verif/tb_top.sv
